FILE: hw/rtl/mfr_pkg.sv
// Package for the Muskingum flow router: payload types, fixed-point constants, register map.
`default_nettype none
package mfr_pkg;

	localparam int unsigned MAX_HALVINGS   = 6;
	localparam int unsigned COEF_FRAC_BITS = 16;
	localparam int unsigned TIME_FRAC_BITS = 16;
	// quotient bits: coefficients never exceed 1.0
	localparam int unsigned QUOT_W = COEF_FRAC_BITS + 1;
	// normalized denominator stays below 2^DEN_W
	localparam int unsigned DEN_W  = 38;
	localparam int unsigned MAG_W  = DEN_W + 2;
	localparam int unsigned NUM_W  = MAG_W + COEF_FRAC_BITS;

	localparam logic [31:0] TRAVEL_RESET = 32'd3600000;
	localparam logic [15:0] WEIGHT_RESET = 16'd13107;
	localparam logic [16:0] X_HALF       = 17'd32768;
	localparam logic [16:0] X_ONE        = 17'd65536;

	// register indexes (paddr word index)
	localparam logic REG_TRAVEL = 1'b0;
	localparam logic REG_WEIGHT = 1'b1;

	typedef struct packed {
		logic [30:0] inflow;
		logic [31:0] step_ms;
		logic        first_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] outflow;
		logic [31:0]        substep_ms;
		logic               last_of_run;
		logic               step_too_small;
		logic               halving_limited;
	} out_item_t;

endpackage
`default_nettype wire

FILE: hw/rtl/mfr_coef_div.sv
// Restoring divider, one quotient bit per cycle, for the routing coefficients.
`default_nettype none
module mfr_coef_div
	import mfr_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [DEN_W-1:0]  den,
	output logic                   done,
	output logic [QUOT_W-1:0]      quot
);

	localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

	logic [DEN_W:0]     rem_q;
	logic [QUOT_W-1:0]  low_q;
	logic [QUOT_W-1:0]  quot_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DEN_W:0]     rem2;
	logic               fits;

	// shift in next numerator bit, trial subtract
	assign rem2 = {rem_q[DEN_W-1:0], low_q[QUOT_W-1]};
	assign fits = rem2 >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			low_q  <= '0;
			quot_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUOT_W);
				rem_q  <= num[NUM_W-1:QUOT_W];
				low_q  <= num[QUOT_W-1:0];
				quot_q <= '0;
			end else if (busy_q) begin
				rem_q  <= fits ? rem2 - {1'b0, den} : rem2;
				low_q  <= {low_q[QUOT_W-2:0], 1'b0};
				quot_q <= {quot_q[QUOT_W-2:0], fits};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

FILE: hw/rtl/muskingum_flow_router_unit.sv
// Muskingum flow router top level: config registers, sequencer, shared multiplier.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------
//   in       | in_valid / in_ready     | in_item  (in_item_t)
//   out      | out_valid / out_ready   | out_item (out_item_t)
//   config   | APB psel/penable/pwrite | paddr, pwdata, prdata
//
// A first sample is accepted and then emitted directly. A routed sample is accepted, then
// goes through setup (h halvings, s normalization shifts, three divisions), then
// through the multiply and sum states once per substep, with 2^h substeps.
// Reset clears state to zero flows and the reset register values.
// in_ready is high only while idle; a full output register stalls the sequencer.
`default_nettype none
module muskingum_flow_router_unit
	import mfr_pkg::*;
#(
	parameter int unsigned MaxHalvings = MAX_HALVINGS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire in_item_t    in_item,
	output logic             out_valid,
	input  wire logic        out_ready,
	output out_item_t        out_item,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int unsigned HW = $clog2(MaxHalvings + 2);
	localparam int unsigned IW = MaxHalvings + 1;
	localparam int unsigned AW = 52;

	typedef enum logic [3:0] {
		S_IDLE, S_FIRST, S_MUP, S_MLO, S_LOCAP, S_HALVE, S_NORM, S_DSET,
		S_DIV, S_MD, S_INEW, S_MC1, S_MC2, S_MC3, S_SUM, S_EMIT
	} state_t;

	state_t              state_q;
	logic [31:0]         travel_q;
	logic [15:0]         weight_q;
	in_item_t            item_q;
	logic [30:0]         prev_in_q;
	logic signed [31:0]  o_q;
	logic                sticky_q;
	logic                limited_q;
	logic signed [32:0]  diff_q;
	logic [HW-1:0]       h_q;
	logic [IW-1:0]       i_q;
	logic [49:0]         up_q, lo_q, dt_q;
	logic [49:0]         su_q, sl_q, sd_q;
	logic [DEN_W-1:0]    den_q;
	logic [1:0]          cidx_q;
	logic                neg_q;
	logic signed [17:0]  c_q [3];
	logic signed [32:0]  inew_q, iold_q;
	logic signed [AW-1:0] acc_q;
	logic signed [67:0]  prod_q;
	logic                out_valid_q;
	out_item_t           out_q;

	logic [16:0]         xs;
	logic signed [33:0]  mul_a, mul_b;
	logic [50:0]         nsum;
	logic [MAG_W-1:0]    mag;
	logic                mag_neg;
	logic [NUM_W-1:0]    div_num;
	logic                div_start;
	logic                div_done;
	logic [QUOT_W-1:0]   div_quot;
	logic signed [39:0]  pscaled;
	logic signed [39:0]  pbias;
	logic signed [AW-1:0] rsum;
	logic signed [AW-COEF_FRAC_BITS-1:0] rnd;
	logic signed [31:0]  osat;
	logic                slot_free;
	logic                emit_now;
	logic                cfg_wr;

	// weight saturated to one half
	assign xs = ({1'b0, weight_q} > X_HALF) ? X_HALF : {1'b0, weight_q};

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_WEIGHT) ? {16'd0, weight_q} : travel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_q <= TRAVEL_RESET;
			weight_q <= WEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_TRAVEL: travel_q <= pwdata;
				REG_WEIGHT: weight_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MUP: begin
				mul_a = {2'b0, travel_q};
				mul_b = {17'd0, X_ONE - xs};
			end
			S_MLO: begin
				mul_a = {2'b0, travel_q};
				mul_b = {17'd0, xs};
			end
			S_MD: begin
				mul_a = 34'(diff_q);
				mul_b = {{(34-IW){1'b0}}, i_q};
			end
			S_MC1: begin
				mul_a = 34'(c_q[0]);
				mul_b = 34'(inew_q);
			end
			S_MC2: begin
				mul_a = 34'(c_q[1]);
				mul_b = 34'(iold_q);
			end
			S_MC3: begin
				mul_a = 34'(c_q[2]);
				mul_b = 34'(o_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// normalization sum and division numerator
	assign nsum = {1'b0, su_q} + {1'b0, sd_q};

	always_comb begin
		unique case (cidx_q)
			2'd0: begin
				mag_neg = sl_q > sd_q;
				mag     = MAG_W'(mag_neg ? sl_q - sd_q : sd_q - sl_q);
			end
			2'd1: begin
				mag_neg = 1'b0;
				mag     = MAG_W'(sd_q + sl_q);
			end
			default: begin
				mag_neg = sd_q > su_q;
				mag     = MAG_W'(mag_neg ? sd_q - su_q : su_q - sd_q);
			end
		endcase
	end

	assign div_num   = {mag, {COEF_FRAC_BITS{1'b0}}} + NUM_W'(den_q >> 1);
	assign div_start = (state_q == S_DSET);

	mfr_coef_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// interpolation: diff*i/2^h truncated toward zero
	assign pbias   = prod_q[39] ? prod_q[39:0] + ((40'sd1 <<< h_q) - 40'sd1) : prod_q[39:0];
	assign pscaled = pbias >>> h_q;

	// round half up, saturate
	assign rsum = acc_q + (AW'(1) <<< (COEF_FRAC_BITS - 1));
	assign rnd  = rsum[AW-1:COEF_FRAC_BITS];
	always_comb begin
		if (rnd > (AW-COEF_FRAC_BITS)'(32'sh7FFFFFFF))
			osat = 32'sh7FFFFFFF;
		else if (rnd < -(AW-COEF_FRAC_BITS)'(33'sh080000000))
			osat = 32'sh80000000;
		else
			osat = rnd[31:0];
	end

	assign slot_free = !out_valid_q || out_ready;
	assign emit_now  = slot_free && (state_q == S_FIRST || state_q == S_EMIT);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			item_q      <= '0;
			prev_in_q   <= '0;
			o_q         <= '0;
			sticky_q    <= 1'b0;
			limited_q   <= 1'b0;
			diff_q      <= '0;
			h_q         <= '0;
			i_q         <= '0;
			up_q        <= '0;
			lo_q        <= '0;
			dt_q        <= '0;
			su_q        <= '0;
			sl_q        <= '0;
			sd_q        <= '0;
			den_q       <= '0;
			cidx_q      <= '0;
			neg_q       <= 1'b0;
			c_q[0]      <= '0;
			c_q[1]      <= '0;
			c_q[2]      <= '0;
			inew_q      <= '0;
			iold_q      <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// output register: load on emit, clear once taken
			if (emit_now)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q <= in_item;
						diff_q <= $signed({2'b0, in_item.inflow}) - $signed({2'b0, prev_in_q});
						h_q    <= '0;
						state_q <= in_item.first_sample ? S_FIRST : S_MUP;
					end
				end
				S_FIRST: begin
					if (slot_free) begin
						out_q       <= '{outflow: '0, substep_ms: '0, last_of_run: 1'b1,
						                 step_too_small: 1'b0, halving_limited: 1'b0};
						prev_in_q   <= item_q.inflow;
						o_q         <= '0;
						sticky_q    <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				S_MUP: state_q <= S_MLO;
				S_MLO: begin
					up_q    <= {prod_q[48:0], 1'b0};
					dt_q    <= {2'b0, item_q.step_ms, {TIME_FRAC_BITS{1'b0}}};
					state_q <= S_LOCAP;
				end
				S_LOCAP: begin
					lo_q    <= {prod_q[48:0], 1'b0};
					state_q <= S_HALVE;
				end
				S_HALVE: begin
					if (dt_q > up_q && h_q < HW'(MaxHalvings)) begin
						dt_q <= dt_q >> 1;
						h_q  <= h_q + 1'b1;
					end else begin
						limited_q <= dt_q > up_q;
						if (h_q == '0 && dt_q < lo_q)
							sticky_q <= 1'b1;
						su_q    <= up_q;
						sl_q    <= lo_q;
						sd_q    <= dt_q;
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (nsum >= (51'd1 << DEN_W)) begin
						su_q <= su_q >> 1;
						sl_q <= sl_q >> 1;
						sd_q <= sd_q >> 1;
					end else if (nsum == '0) begin
						// zero denominator: outflow follows inflow
						c_q[0]  <= 18'sd1 <<< COEF_FRAC_BITS;
						c_q[1]  <= '0;
						c_q[2]  <= '0;
						i_q     <= IW'(1);
						iold_q  <= $signed({2'b0, prev_in_q});
						state_q <= S_MD;
					end else begin
						den_q   <= nsum[DEN_W-1:0];
						cidx_q  <= '0;
						state_q <= S_DSET;
					end
				end
				S_DSET: begin
					neg_q   <= mag_neg;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						c_q[cidx_q] <= neg_q ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
						if (cidx_q == 2'd2) begin
							i_q     <= IW'(1);
							iold_q  <= $signed({2'b0, prev_in_q});
							state_q <= S_MD;
						end else begin
							cidx_q  <= cidx_q + 1'b1;
							state_q <= S_DSET;
						end
					end
				end
				S_MD: state_q <= S_INEW;
				S_INEW: begin
					inew_q  <= $signed({2'b0, prev_in_q}) + pscaled[32:0];
					state_q <= S_MC1;
				end
				S_MC1: state_q <= S_MC2;
				S_MC2: begin
					acc_q   <= prod_q[AW-1:0];
					state_q <= S_MC3;
				end
				S_MC3: begin
					acc_q   <= acc_q + prod_q[AW-1:0];
					state_q <= S_SUM;
				end
				S_SUM: begin
					acc_q   <= acc_q + prod_q[AW-1:0];
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) begin
						out_q <= '{outflow: osat,
						           substep_ms: dt_q[TIME_FRAC_BITS+31:TIME_FRAC_BITS],
						           last_of_run: i_q == (IW'(1) << h_q),
						           step_too_small: sticky_q,
						           halving_limited: limited_q};
						o_q    <= osat;
						iold_q <= inew_q;
						if (i_q == (IW'(1) << h_q)) begin
							prev_in_q <= item_q.inflow;
							state_q   <= S_IDLE;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_MD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef NO_ASSERTIONS
	a_h_bound: assert property (@(posedge clk) disable iff (!arst_n)
		h_q <= HW'(MaxHalvings))
		else $error("halving count beyond limit");
	a_first_path: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_item.first_sample |=> state_q == S_FIRST)
		else $error("first sample did not take the reset path");
	a_run_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.last_of_run |-> state_q != S_IDLE)
		else $error("idle while a substep run is still open");
	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> div_quot <= (QUOT_W'(1) << COEF_FRAC_BITS))
		else $error("coefficient above one");
`endif

endmodule
`default_nettype wire
